// ===== design/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types and constants of the Q24.8 fixed-point ALU.
// ----------------------------------------------------------------------------
package fpa_pkg;

   localparam int WordBits = 32;
   localparam int FracBits = 8;
   localparam int NqBits   = WordBits + FracBits + 1;

   localparam logic [WordBits-1:0] MaxVal = {1'b0, {(WordBits-1){1'b1}}};
   localparam logic [WordBits-1:0] MinVal = {1'b1, {(WordBits-1){1'b0}}};

   typedef enum logic [3:0] {
      OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_GT, OP_LT, OP_GE, OP_LE,
      OP_EQ, OP_NE, OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TO_INT, OP_FROM_INT
   } op_type;

   typedef struct packed {
      op_type                       op;
      logic                         neg;
      logic [WordBits-1:0]          res;
      logic                         cmp;
      logic                         ovf;
      logic                         dbz;
      logic signed [2*WordBits-1:0] prod;
      logic [WordBits-1:0]          rem;
      logic [NqBits-1:0]            nq;
      logic [WordBits-1:0]          den;
   } stage_type;

endpackage

// ===== design/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// Entry stage: decodes the request, computes the results of all but multiply
// and divide, registers the product and loads the divide operands.
// ----------------------------------------------------------------------------
module fpa_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   output logic                           in_ready,
   input  logic [3:0]                     op,
   input  logic signed [31:0]             a_raw,
   input  logic signed [31:0]             b_raw,
   output logic                           out_valid,
   input  logic                           out_ready,
   output fpa_pkg::stage_type             out_data
);

   localparam int W = fpa_pkg::WordBits;
   localparam int FPA_PAD = fpa_pkg::FracBits;

   logic               valid_ff;
   fpa_pkg::stage_type data_ff, data_in;
   logic               adv;

   logic signed [W:0]  sum, dif, inc, dec;
   logic [W-1:0]       ma, mb, ti;
   logic [W+FPA_PAD:0] fi;

   function automatic logic [W:0] sat_s(input logic [W+FPA_PAD:0] v);
      logic [W:0] r;
      if (v[W+FPA_PAD:W-1] != {(FPA_PAD+2){v[W+FPA_PAD]}})
         r = {1'b1, v[W+FPA_PAD] ? fpa_pkg::MinVal : fpa_pkg::MaxVal};
      else
         r = {1'b0, v[W-1:0]};
      return r;
   endfunction

   assign adv       = !valid_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      sum = {a_raw[W-1], a_raw} + {b_raw[W-1], b_raw};
      dif = {a_raw[W-1], a_raw} - {b_raw[W-1], b_raw};
      inc = {a_raw[W-1], a_raw} + (W+1)'(1);
      dec = {a_raw[W-1], a_raw} - (W+1)'(1);
      ma  = a_raw[W-1] ? W'(-a_raw) : a_raw;
      mb  = b_raw[W-1] ? W'(-b_raw) : b_raw;
      ti  = ma >> FPA_PAD;
      fi  = {b_raw[W-1], b_raw, {FPA_PAD{1'b0}}};

      data_in      = '0;
      data_in.op   = fpa_pkg::op_type'(op);
      data_in.neg  = a_raw[W-1] ^ b_raw[W-1];
      data_in.prod = (2*W)'(a_raw) * (2*W)'(b_raw);
      data_in.nq   = {ma, {(FPA_PAD+1){1'b0}}};
      data_in.den  = mb;
      case (fpa_pkg::op_type'(op))
         fpa_pkg::OP_ADD: {data_in.ovf, data_in.res} = sat_s({{FPA_PAD{sum[W]}}, sum});
         fpa_pkg::OP_SUB: {data_in.ovf, data_in.res} = sat_s({{FPA_PAD{dif[W]}}, dif});
         fpa_pkg::OP_INC: {data_in.ovf, data_in.res} = sat_s({{FPA_PAD{inc[W]}}, inc});
         fpa_pkg::OP_DEC: {data_in.ovf, data_in.res} = sat_s({{FPA_PAD{dec[W]}}, dec});
         fpa_pkg::OP_DIV: data_in.dbz = (b_raw == '0);
         fpa_pkg::OP_GT:  data_in.cmp = (a_raw >  b_raw);
         fpa_pkg::OP_LT:  data_in.cmp = (a_raw <  b_raw);
         fpa_pkg::OP_GE:  data_in.cmp = (a_raw >= b_raw);
         fpa_pkg::OP_LE:  data_in.cmp = (a_raw <= b_raw);
         fpa_pkg::OP_EQ:  data_in.cmp = (a_raw == b_raw);
         fpa_pkg::OP_NE:  data_in.cmp = (a_raw != b_raw);
         fpa_pkg::OP_MIN: data_in.res = (a_raw < b_raw) ? a_raw : b_raw;
         fpa_pkg::OP_MAX: data_in.res = (a_raw > b_raw) ? a_raw : b_raw;
         fpa_pkg::OP_TO_INT: data_in.res = a_raw[W-1] ? W'(-ti) : ti;
         fpa_pkg::OP_FROM_INT: {data_in.ovf, data_in.res} = sat_s(fi);
         default: data_in.res = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/fpa_div_cell.sv =====
// ----------------------------------------------------------------------------
// fpa_div_cell
// One divider cell: one restoring quotient bit, then hand on to the next.
// ----------------------------------------------------------------------------
module fpa_div_cell (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fpa_pkg::stage_type in_data,
   output logic               out_valid,
   input  logic               out_ready,
   output fpa_pkg::stage_type out_data
);

   localparam int W  = fpa_pkg::WordBits;
   localparam int NQ = fpa_pkg::NqBits;

   logic               valid_ff;
   fpa_pkg::stage_type data_ff, data_in;
   logic               adv;
   logic [W:0]         trial, diff;
   logic               ge;

   assign adv       = !valid_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      trial   = {in_data.rem, in_data.nq[NQ-1]};
      diff    = trial - {1'b0, in_data.den};
      ge      = (trial >= {1'b0, in_data.den});
      data_in = in_data;
      data_in.rem = ge ? diff[W-1:0] : trial[W-1:0];
      data_in.nq  = {in_data.nq[NQ-2:0], ge};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         data_ff <= data_in;
      end
   end

endmodule

// ===== design/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// Exit stage: rounds and saturates multiply and divide, holds the response.
// ----------------------------------------------------------------------------
module fpa_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  fpa_pkg::stage_type in_data,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_raw,
   output logic               rsp_compare_true,
   output logic               rsp_overflowed,
   output logic               rsp_divided_by_zero
);

   localparam int W  = fpa_pkg::WordBits;
   localparam int F  = fpa_pkg::FracBits;
   localparam int NQ = fpa_pkg::NqBits;

   logic          valid_ff;
   logic [W-1:0]  res_ff, res_in;
   logic          cmp_ff, ovf_ff, ovf_in, dbz_ff;
   logic          adv;
   logic [2*W-1:0] pm, rm, qm;

   function automatic logic [W:0] sat_m(input logic [2*W-1:0] m, input logic neg);
      logic [W:0] r;
      if (neg) begin
         if (m > {{W{1'b0}}, fpa_pkg::MinVal}) r = {1'b1, fpa_pkg::MinVal};
         else                                  r = {1'b0, W'(-m)};
      end else begin
         if (m > {{W{1'b0}}, fpa_pkg::MaxVal}) r = {1'b1, fpa_pkg::MaxVal};
         else                                  r = {1'b0, m[W-1:0]};
      end
      return r;
   endfunction

   assign adv                 = !valid_ff || rsp_ready;
   assign in_ready            = adv;
   assign rsp_valid           = valid_ff;
   assign rsp_result_raw      = res_ff;
   assign rsp_compare_true    = cmp_ff;
   assign rsp_overflowed      = ovf_ff;
   assign rsp_divided_by_zero = dbz_ff;

   always_comb begin
      pm = in_data.prod[2*W-1] ? (2*W)'(-in_data.prod) : in_data.prod;
      rm = (pm + ((2*W)'(1) << (F-1))) >> F;
      qm = ({{(2*W-NQ){1'b0}}, in_data.nq} + (2*W)'(1)) >> 1;
      case (in_data.op)
         fpa_pkg::OP_MUL: {ovf_in, res_in} = sat_m(rm, in_data.neg);
         fpa_pkg::OP_DIV: begin
            if (in_data.dbz) {ovf_in, res_in} = '0;
            else             {ovf_in, res_in} = sat_m(qm, in_data.neg);
         end
         default: {ovf_in, res_in} = {in_data.ovf, in_data.res};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (adv) begin
         valid_ff <= in_valid;
      end
      if (adv) begin
         res_ff <= res_in;
         cmp_ff <= in_data.cmp;
         ovf_ff <= ovf_in;
         dbz_ff <= in_data.dbz;
      end
   end

endmodule

// ===== design/fixed_point_alu_q24_8.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_q24_8
// Signed Q24.8 ALU: entry stage, a chain of restoring divider cells, exit stage.
// ----------------------------------------------------------------------------
// Every opcode goes from request to response through the entry stage,
// one divider cell per quotient bit and the output register.
// Throughput: one request per cycle unless rsp_ready stalls; each cell holds one.
// Reset: synchronous, clears all valid flags; payload registers are not reset.
module fixed_point_alu_q24_8 (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [3:0]         req_op,
   input  logic signed [31:0] req_a_raw,
   input  logic signed [31:0] req_b_raw,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [31:0] rsp_result_raw,
   output logic               rsp_compare_true,
   output logic               rsp_overflowed,
   output logic               rsp_divided_by_zero
);

   localparam int NQ = fpa_pkg::NqBits;

   logic               v   [0:NQ];
   logic               rdy [0:NQ];
   fpa_pkg::stage_type d   [0:NQ];

   fpa_front u_front (
      .clock(clock), .reset(reset),
      .in_valid(req_valid), .in_ready(req_ready),
      .op(req_op), .a_raw(req_a_raw), .b_raw(req_b_raw),
      .out_valid(v[0]), .out_ready(rdy[0]), .out_data(d[0])
   );

   for (genvar i = 0; i < NQ; i++) begin : g_cell
      fpa_div_cell u_cell (
         .clock(clock), .reset(reset),
         .in_valid(v[i]), .in_ready(rdy[i]), .in_data(d[i]),
         .out_valid(v[i+1]), .out_ready(rdy[i+1]), .out_data(d[i+1])
      );
   end

   fpa_back u_back (
      .clock(clock), .reset(reset),
      .in_valid(v[NQ]), .in_ready(rdy[NQ]), .in_data(d[NQ]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready),
      .rsp_result_raw(rsp_result_raw), .rsp_compare_true(rsp_compare_true),
      .rsp_overflowed(rsp_overflowed), .rsp_divided_by_zero(rsp_divided_by_zero)
   );

endmodule

// ===== design/fpa_checker.sv =====
// ----------------------------------------------------------------------------
// fpa_checker
// Port-level checks of the fixed-point ALU, bound to the top level.
// ----------------------------------------------------------------------------
module fpa_checker (
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic signed [31:0] rsp_result_raw,
   input logic               rsp_compare_true,
   input logic               rsp_overflowed,
   input logic               rsp_divided_by_zero
);

   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result_raw))
      else $error("stalled response changed");

   a_cmp_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_compare_true |-> !rsp_overflowed && !rsp_divided_by_zero
         && rsp_result_raw == 0)
      else $error("compare with arithmetic flags");

   a_dbz: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divided_by_zero |-> rsp_result_raw == 0 && !rsp_overflowed)
      else $error("divide by zero result not zero");

   a_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_overflowed |->
         rsp_result_raw == 32'sh7fffffff || rsp_result_raw == 32'sh80000000)
      else $error("overflow without saturated value");

endmodule

bind fixed_point_alu_q24_8 fpa_checker u_fpa_checker (.*);

// ===== sim/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Checks the Q24.8 fixed-point ALU against an exact fixed-point predictor.
// A directed request table covers operand extremes, every opcode, rounding,
// divide by zero and saturation. Random requests follow with bursty sending
// and a patterned response stall.
// ----------------------------------------------------------------------------
module tb_top;

   typedef struct packed {
      logic signed [31:0] res;
      logic               cmp;
      logic               ovf;
      logic               dbz;
   } alu_result_type;

   typedef struct {
      fpa_pkg::op_type    op;
      logic signed [31:0] a;
      logic signed [31:0] b;
      logic               known;
      alu_result_type     want;
   } req_row_type;

   localparam logic signed [31:0] SMAX = 32'sh7fffffff;
   localparam logic signed [31:0] SMIN = 32'sh80000000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [3:0]         req_op = 4'd0;
   logic signed [31:0] req_a_raw = '0;
   logic signed [31:0] req_b_raw = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [31:0] rsp_result_raw;
   logic               rsp_compare_true;
   logic               rsp_overflowed;
   logic               rsp_divided_by_zero;

   alu_result_type pending_results[$];
   int             fail_count = 0;
   bit             sending_done = 1'b0;

   fixed_point_alu_q24_8 DUT (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic logic signed [31:0] clamp64(input logic signed [63:0] v,
                                                  inout logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return SMAX;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return SMIN;
      end
      return v[31:0];
   endfunction

   function automatic alu_result_type alu_predict(input fpa_pkg::op_type op,
                                                  input logic signed [31:0] a,
                                                  input logic signed [31:0] b);
      alu_result_type     r;
      logic signed [63:0] wa, wb, sv;
      logic [63:0]        m, num, den;
      logic               neg;
      r = '{res: '0, cmp: 1'b0, ovf: 1'b0, dbz: 1'b0};
      wa = a;
      wb = b;
      neg = (a < 0) != (b < 0);
      case (op)
         fpa_pkg::OP_ADD: r.res = clamp64(wa + wb, r.ovf);
         fpa_pkg::OP_SUB: r.res = clamp64(wa - wb, r.ovf);
         fpa_pkg::OP_MUL: begin
            sv = wa * wb;
            m = sv < 0 ? -sv : sv;
            m = (m + 64'd128) >> 8;
            sv = m;
            r.res = clamp64(neg ? -sv : sv, r.ovf);
         end
         fpa_pkg::OP_DIV: begin
            if (b == 0) begin
               r.dbz = 1'b1;
            end else begin
               num = (wa < 0 ? -wa : wa) << 8;
               den = wb < 0 ? -wb : wb;
               m = (2 * num + den) / (2 * den);
               sv = m;
               r.res = clamp64(neg ? -sv : sv, r.ovf);
            end
         end
         fpa_pkg::OP_GT: r.cmp = a > b;
         fpa_pkg::OP_LT: r.cmp = a < b;
         fpa_pkg::OP_GE: r.cmp = a >= b;
         fpa_pkg::OP_LE: r.cmp = a <= b;
         fpa_pkg::OP_EQ: r.cmp = a == b;
         fpa_pkg::OP_NE: r.cmp = a != b;
         fpa_pkg::OP_MIN: r.res = a < b ? a : b;
         fpa_pkg::OP_MAX: r.res = a > b ? a : b;
         fpa_pkg::OP_INC: r.res = clamp64(wa + 1, r.ovf);
         fpa_pkg::OP_DEC: r.res = clamp64(wa - 1, r.ovf);
         fpa_pkg::OP_TO_INT: begin
            m = (wa < 0 ? -wa : wa) >> 8;
            sv = m;
            r.res = wa < 0 ? -sv : sv;
         end
         default: r.res = clamp64(wb * 64'sd256, r.ovf);
      endcase
      return r;
   endfunction

   task automatic report(input string what, input logic [31:0] got,
                         input logic [31:0] want);
      $display("mismatch %s: got %h want %h", what, got, want);
      fail_count++;
   endtask

   task automatic send_request(input fpa_pkg::op_type op, input logic signed [31:0] a,
                               input logic signed [31:0] b);
      req_valid <= 1'b1;
      req_op    <= op;
      req_a_raw <= a;
      req_b_raw <= b;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   function automatic logic signed [31:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return SMAX - $urandom_range(0, 3);
         1: return SMIN + $urandom_range(0, 3);
         2: return $signed($urandom_range(0, 8)) - 4;
         3: return $signed($urandom_range(0, 4095)) - 2048;
         4: return $signed($urandom_range(0, 32'h3ffff)) - 32'sh20000;
         default: return $urandom;
      endcase
   endfunction

   // directed table, then random bursts
   initial begin
      req_row_type    rows[$];
      alu_result_type z;
      int             burst;
      int             gap;
      z = '{res: '0, cmp: 1'b0, ovf: 1'b0, dbz: 1'b0};
      rows = '{
         '{fpa_pkg::OP_ADD, SMAX, 32'sd1, 1'b1, '{SMAX, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_ADD, SMIN, -32'sd1, 1'b1, '{SMIN, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_SUB, SMIN, 32'sd1, 1'b1, '{SMIN, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_SUB, 32'sd0, SMIN, 1'b1, '{SMAX, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_MUL, 32'sd384, -32'sd384, 1'b0, z},
         '{fpa_pkg::OP_MUL, 32'sd1, 32'sd128, 1'b0, z},
         '{fpa_pkg::OP_MUL, -32'sd1, 32'sd128, 1'b0, z},
         '{fpa_pkg::OP_MUL, SMIN, SMIN, 1'b1, '{SMAX, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_DIV, 32'sd256, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b0, 1'b1}},
         '{fpa_pkg::OP_DIV, SMIN, 32'sd0, 1'b1, '{32'sd0, 1'b0, 1'b0, 1'b1}},
         '{fpa_pkg::OP_DIV, SMIN, 32'sd1, 1'b1, '{SMIN, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_DIV, -32'sd1, 32'sd512, 1'b0, z},
         '{fpa_pkg::OP_DIV, SMAX, SMIN, 1'b0, z},
         '{fpa_pkg::OP_GT, SMAX, SMIN, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
         '{fpa_pkg::OP_LT, SMAX, SMIN, 1'b1, z},
         '{fpa_pkg::OP_GE, 32'sd5, 32'sd5, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
         '{fpa_pkg::OP_LE, SMIN, SMIN, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
         '{fpa_pkg::OP_EQ, -32'sd1, 32'sd1, 1'b1, z},
         '{fpa_pkg::OP_NE, -32'sd1, 32'sd1, 1'b1, '{32'sd0, 1'b1, 1'b0, 1'b0}},
         '{fpa_pkg::OP_MIN, SMIN, SMAX, 1'b1, '{SMIN, 1'b0, 1'b0, 1'b0}},
         '{fpa_pkg::OP_MAX, SMIN, SMAX, 1'b1, '{SMAX, 1'b0, 1'b0, 1'b0}},
         '{fpa_pkg::OP_INC, SMAX, 32'sd0, 1'b1, '{SMAX, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_DEC, SMIN, 32'sd0, 1'b1, '{SMIN, 1'b0, 1'b1, 1'b0}},
         '{fpa_pkg::OP_TO_INT, -32'sd257, 32'sd0, 1'b1, '{-32'sd1, 1'b0, 1'b0, 1'b0}},
         '{fpa_pkg::OP_FROM_INT, SMAX, 32'sh00800000, 1'b1, '{SMAX, 1'b0, 1'b1, 1'b0}}
      };
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (rows[i]) begin
         if (rows[i].known &&
             alu_predict(rows[i].op, rows[i].a, rows[i].b) != rows[i].want)
            report("table row", 32'(i), 32'd0);
         pending_results.push_back(alu_predict(rows[i].op, rows[i].a, rows[i].b));
         send_request(rows[i].op, rows[i].a, rows[i].b);
      end
      for (int n = 0; n < 750; ) begin
         burst = $urandom_range(1, 40);
         for (int k = 0; k < burst && n < 750; k++, n++) begin
            fpa_pkg::op_type    op;
            logic signed [31:0] a, b;
            op = fpa_pkg::op_type'($urandom_range(0, 15));
            a = pick_operand();
            b = ($urandom_range(0, 9) == 0) ? 32'sd0 : pick_operand();
            pending_results.push_back(alu_predict(op, a, b));
            send_request(op, a, b);
         end
         gap = $urandom_range(0, 1) ? $urandom_range(1, 12) : 0;
         if (gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
      req_valid <= 1'b0;
      sending_done = 1'b1;
   end

   // response stall pattern: long open windows, then choppy stretches
   initial begin
      int phase = 0;
      forever begin
         @(negedge clock);
         phase++;
         if (phase % 300 < 100) rsp_ready <= 1'b1;
         else if (phase % 300 < 200) rsp_ready <= ($urandom_range(0, 3) != 0);
         else rsp_ready <= ($urandom_range(0, 3) == 0);
      end
   end

   always @(posedge clock) begin
      alu_result_type w;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_results.size() == 0) begin
            report("unexpected response", rsp_result_raw, 32'd0);
         end else begin
            w = pending_results.pop_front();
            if (rsp_result_raw !== w.res) report("result_raw", rsp_result_raw, w.res);
            if (rsp_compare_true !== w.cmp)
               report("compare_true", 32'(rsp_compare_true), 32'(w.cmp));
            if (rsp_overflowed !== w.ovf)
               report("overflowed", 32'(rsp_overflowed), 32'(w.ovf));
            if (rsp_divided_by_zero !== w.dbz)
               report("divided_by_zero", 32'(rsp_divided_by_zero), 32'(w.dbz));
         end
      end
   end

   initial begin
      wait (sending_done);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0) $display("PASSED: all results match");
      else $display("FAILED: results differ");
      $finish;
   end

   initial begin
      #2000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
